// ----- hw/rtl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Q8.8 field types, word structs, matrix layout and register indexes.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DIM       = 4;
    localparam int ELEM_W    = 16;
    localparam int ROW_W     = DIM * ELEM_W;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_BITS = 8;
    localparam int SHIFT_W   = SUM_W - FRAC_BITS;
    localparam int INDEX_W   = 8;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_ROW0 = 8'd0;
    localparam logic [INDEX_W-1:0] REG_ROW1 = 8'd1;
    localparam logic [INDEX_W-1:0] REG_ROW2 = 8'd2;
    localparam logic [INDEX_W-1:0] REG_ROW3 = 8'd3;

    typedef logic signed [ELEM_W-1:0] q88_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef row_t [DIM-1:0]           mat_t;

    // identity matrix, one Q8.8 one on the diagonal
    localparam mat_t MATRIX_RESET = {
        64'h0100_0000_0000_0000,
        64'h0000_0100_0000_0000,
        64'h0000_0000_0100_0000,
        64'h0000_0000_0000_0100
    };

    typedef struct packed {
        q88_t in_x;
        q88_t in_y;
        q88_t in_z;
        q88_t in_w;
    } vec_in_t;

    typedef struct packed {
        q88_t out_x;
        q88_t out_y;
        q88_t out_z;
        q88_t out_w;
        logic saturated;
    } vec_out_t;

    // products, pair sums and row sums, row index outer
    typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0] prod_mat_t;
    typedef logic [DIM-1:0][1:0][PAIR_W-1:0]     pair_mat_t;
    typedef logic [DIM-1:0][SUM_W-1:0]           sum_vec_t;

    // handshake between pipeline sections
    typedef struct packed {
        logic valid;
    } fwd_t;

    typedef struct packed {
        logic ready;
    } bwd_t;

endpackage

// ----- hw/rtl/mvt_mult.sv -----
// ----------------------------------------------------------------------------
// mvt_mult: product stage
// Sixteen parallel 16x16 signed multiplies, one per matrix entry, registered.
// ----------------------------------------------------------------------------
module mvt_mult
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mvt_pkg::vec_in_t   in_data,
    input  mvt_pkg::mat_t      matrix,
    output mvt_pkg::fwd_t      down_fwd,
    input  mvt_pkg::bwd_t      down_bwd,
    output mvt_pkg::prod_mat_t prod
);

    logic                      valid_reg;
    logic                      load;
    mvt_pkg::prod_mat_t        prod_reg;
    mvt_pkg::prod_mat_t        prod_next;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::ELEM_W-1:0] vec;

    assign in_ready = !valid_reg || down_bwd.ready;
    assign load     = in_valid && in_ready;

    // column order of the vector
    assign vec[0] = in_data.in_x;
    assign vec[1] = in_data.in_y;
    assign vec[2] = in_data.in_z;
    assign vec[3] = in_data.in_w;

    // one product per matrix entry
    always_comb
    begin
        for (int i = 0; i < mvt_pkg::DIM; i++)
        begin
            for (int j = 0; j < mvt_pkg::DIM; j++)
            begin
                prod_next[i][j] = $signed(matrix[i][mvt_pkg::ELEM_W*j +: mvt_pkg::ELEM_W])
                                * $signed(vec[j]);
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign down_fwd.valid = valid_reg;
    assign prod           = prod_reg;

endmodule

// ----- hw/rtl/mvt_sum.sv -----
// ----------------------------------------------------------------------------
// mvt_sum: adder tree
// Two registered levels: pairs of products, then full row sums.
// ----------------------------------------------------------------------------
module mvt_sum
(
    input  logic               clk,
    input  logic               rst_n,
    input  mvt_pkg::fwd_t      up_fwd,
    output mvt_pkg::bwd_t      up_bwd,
    input  mvt_pkg::prod_mat_t prod,
    output mvt_pkg::fwd_t      down_fwd,
    input  mvt_pkg::bwd_t      down_bwd,
    output mvt_pkg::sum_vec_t  sum
);

    logic               pair_valid_reg;
    logic               sum_valid_reg;
    logic               pair_ready;
    logic               sum_ready;
    mvt_pkg::pair_mat_t pair_reg;
    mvt_pkg::pair_mat_t pair_next;
    mvt_pkg::sum_vec_t  sum_reg;
    mvt_pkg::sum_vec_t  sum_next;

    assign sum_ready  = !sum_valid_reg || down_bwd.ready;
    assign pair_ready = !pair_valid_reg || sum_ready;

    // first level: product pairs, sign extended by one bit
    always_comb
    begin
        for (int i = 0; i < mvt_pkg::DIM; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                pair_next[i][k] =
                    mvt_pkg::PAIR_W'($signed(prod[i][2*k]))
                  + mvt_pkg::PAIR_W'($signed(prod[i][2*k+1]));
            end
        end
    end

    // second level: row sums
    always_comb
    begin
        for (int i = 0; i < mvt_pkg::DIM; i++)
        begin
            sum_next[i] = mvt_pkg::SUM_W'($signed(pair_reg[i][0]))
                        + mvt_pkg::SUM_W'($signed(pair_reg[i][1]));
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pair_ready)
            begin
                pair_valid_reg <= up_fwd.valid;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= pair_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pair_ready && up_fwd.valid)
        begin
            pair_reg <= pair_next;
        end
        if (sum_ready && pair_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign up_bwd.ready   = pair_ready;
    assign down_fwd.valid = sum_valid_reg;
    assign sum            = sum_reg;

endmodule

// ----- hw/rtl/mvt_sat.sv -----
// ----------------------------------------------------------------------------
// mvt_sat: scale and saturate, output register
// Floor shift by the fraction bits, clip to 16 bits, flag any clipping.
// ----------------------------------------------------------------------------
module mvt_sat
(
    input  logic              clk,
    input  logic              rst_n,
    input  mvt_pkg::fwd_t     up_fwd,
    output mvt_pkg::bwd_t     up_bwd,
    input  mvt_pkg::sum_vec_t sum,
    output logic              out_valid,
    input  logic              out_ready,
    output mvt_pkg::vec_out_t out_data
);

    logic                                         valid_reg;
    logic                                         ready;
    mvt_pkg::vec_out_t                            data_reg;
    mvt_pkg::vec_out_t                            data_next;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::ELEM_W-1:0] comp;
    logic [mvt_pkg::DIM-1:0]                      clip;

    assign ready = !valid_reg || out_ready;

    // arithmetic shift rounds toward minus infinity
    always_comb
    begin
        logic signed [mvt_pkg::SHIFT_W-1:0] sh;
        for (int i = 0; i < mvt_pkg::DIM; i++)
        begin
            sh = mvt_pkg::SHIFT_W'($signed(sum[i]) >>> mvt_pkg::FRAC_BITS);
            // in range when all bits above the low 15 agree with the sign
            clip[i] = !((&sh[mvt_pkg::SHIFT_W-1:mvt_pkg::ELEM_W-1])
                     || !(|sh[mvt_pkg::SHIFT_W-1:mvt_pkg::ELEM_W-1]));
            if (clip[i])
            begin
                comp[i] = sh[mvt_pkg::SHIFT_W-1] ? 16'h8000 : 16'h7fff;
            end
            else
            begin
                comp[i] = sh[mvt_pkg::ELEM_W-1:0];
            end
        end
    end

    always_comb
    begin
        data_next.out_x     = comp[0];
        data_next.out_y     = comp[1];
        data_next.out_z     = comp[2];
        data_next.out_w     = comp[3];
        data_next.saturated = |clip;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_fwd.valid;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (ready && up_fwd.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign up_bwd.ready = ready;
    assign out_valid    = valid_reg;
    assign out_data     = data_reg;

endmodule

// ----- hw/rtl/mat4_vec4_transform.sv -----
// ----------------------------------------------------------------------------
// mat4_vec4_transform: 4x4 matrix times 4-component vector, signed Q8.8
// Top level: matrix row registers and the four-stage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one vector word (x, y, z, w, Q8.8).
//   out_valid/out_ready/out_data carry one result word per vector: each
//   component is a matrix row dotted with the vector, floor shifted by 8
//   and clipped to 16 bits; saturated is set if any component was clipped.
//   cfg_we/cfg_index/cfg_data write matrix row cfg_index (0 to 3); other
//   indexes are ignored. Write rows only while idle.
//   Four register stages: multiply, pair add, row add, shift and saturate.
//   The multiply stage loads at the input accept edge; the word then
//   moves through the pair add, row add and output registers in turn.
//   Throughput is one vector per cycle while out_ready stays high, set by
//   the 16 parallel multipliers. When the receiver stalls, each stage holds
//   its word and empty stages still fill, so up to 4 words are held before
//   in_ready falls; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
module mat4_vec4_transform
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mvt_pkg::vec_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mvt_pkg::vec_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [mvt_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [mvt_pkg::ROW_W-1:0]     cfg_data
);

    mvt_pkg::mat_t      matrix_reg;
    mvt_pkg::fwd_t      mult_fwd;
    mvt_pkg::bwd_t      mult_bwd;
    mvt_pkg::fwd_t      sum_fwd;
    mvt_pkg::bwd_t      sum_bwd;
    mvt_pkg::prod_mat_t prod;
    mvt_pkg::sum_vec_t  sum;

    // matrix row registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= mvt_pkg::MATRIX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mvt_pkg::REG_ROW0: matrix_reg[0] <= cfg_data;
                mvt_pkg::REG_ROW1: matrix_reg[1] <= cfg_data;
                mvt_pkg::REG_ROW2: matrix_reg[2] <= cfg_data;
                mvt_pkg::REG_ROW3: matrix_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // products
    mvt_mult u_mult
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .matrix   (matrix_reg),
        .down_fwd (mult_fwd),
        .down_bwd (mult_bwd),
        .prod     (prod)
    );

    // adder tree
    mvt_sum u_sum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_fwd   (mult_fwd),
        .up_bwd   (mult_bwd),
        .prod     (prod),
        .down_fwd (sum_fwd),
        .down_bwd (sum_bwd),
        .sum      (sum)
    );

    // shift, saturate and output register
    mvt_sat u_sat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_fwd    (sum_fwd),
        .up_bwd    (sum_bwd),
        .sum       (sum),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sim/mat4_vec4_transform_test.sv -----
// ----------------------------------------------------------------------------
// mat4_vec4_transform_test: self-checking bench for the 4x4 Q8.8 transform
// Loads matrix rows through the register port and streams vectors in.
// Every result word is checked against a local Q8.8 matrix-vector predictor.
// The run covers the identity reset, extreme matrices and vectors, clipping,
// floor rounding of negative sums and ignored register indexes. Both
// handshakes idle at random, and a long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module mat4_vec4_transform_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int LATENCY     = 4;
    localparam int QUIET_LIMIT = 4000;
    localparam int IDLE_PCT    = 36;

    // indexes outside the matrix, writes there are dropped
    localparam logic [INDEX_W-1:0] REG_PAST_LAST = 8'd4;
    localparam logic [INDEX_W-1:0] REG_TOP       = 8'hFF;

    localparam q88_t Q_ONE  = 16'sh0100;
    localparam q88_t Q_LSB  = 16'sh0001;
    localparam q88_t Q_MAXV = 16'sh7FFF;
    localparam q88_t Q_MINV = -16'sh8000;

    typedef enum int {
        ROWS_FULL,
        ROWS_SMALL,
        ROWS_MAX,
        ROWS_MIN,
        ROWS_ZERO,
        ROWS_IDENT
    } row_kind_e;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    vec_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    vec_out_t             out_data;
    logic                 cfg_we    = 1'b0;
    logic [INDEX_W-1:0]   cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data  = '0;

    // local copy of the matrix as the block should hold it
    row_t     row_shadow [DIM];
    vec_out_t pending_results [$];

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int hold_left      = 0;

    int error_count    = 0;
    int vectors_sent   = 0;
    int results_seen   = 0;
    int clipped_seen   = 0;
    int matrices_used  = 0;
    int quiet_cycles   = 0;

    mat4_vec4_transform dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // rows dotted with the vector, floor shift by 8, clip to 16 bits
    function automatic vec_out_t transform_vector(input vec_in_t v);
        longint   comp [DIM];
        longint   acc;
        longint   sum;
        q88_t     entry;
        q88_t     res [DIM];
        logic     clip;
        vec_out_t o;
        comp[0] = v.in_x;
        comp[1] = v.in_y;
        comp[2] = v.in_z;
        comp[3] = v.in_w;
        clip = 1'b0;
        for (int i = 0; i < DIM; i++)
        begin
            acc = 0;
            for (int j = 0; j < DIM; j++)
            begin
                entry = row_shadow[i][ELEM_W*j +: ELEM_W];
                acc += longint'(entry) * comp[j];
            end
            sum = acc >>> FRAC_BITS;
            if (sum > 32767)
            begin
                sum  = 32767;
                clip = 1'b1;
            end
            else if (sum < -32768)
            begin
                sum  = -32768;
                clip = 1'b1;
            end
            res[i] = q88_t'(sum);
        end
        o.out_x     = res[0];
        o.out_y     = res[1];
        o.out_z     = res[2];
        o.out_w     = res[3];
        o.saturated = clip;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic q88_t random_entry();
        case ($urandom_range(0, 7))
            0:       return Q_MAXV;
            1:       return Q_MINV;
            2:       return '0;
            3:       return -16'sh0001;
            4:       return q88_t'(int'($urandom_range(0, 1023)) - 512);
            default: return q88_t'($urandom);
        endcase
    endfunction

    function automatic vec_in_t random_vector();
        vec_in_t v;
        v.in_x = random_entry();
        v.in_y = random_entry();
        v.in_z = random_entry();
        v.in_w = random_entry();
        return v;
    endfunction

    function automatic vec_in_t make_vector(input q88_t x, input q88_t y,
                                            input q88_t z, input q88_t w);
        vec_in_t v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.in_w = w;
        return v;
    endfunction

    // one entry at column col, zero elsewhere
    function automatic row_t diag_row(input int col, input q88_t e);
        row_t r;
        r = '0;
        r[ELEM_W*col +: ELEM_W] = e;
        return r;
    endfunction

    function automatic row_t build_row(input row_kind_e kind, input int row);
        row_t r;
        r = '0;
        for (int j = 0; j < DIM; j++)
        begin
            case (kind)
                ROWS_FULL:  r[ELEM_W*j +: ELEM_W] = random_entry();
                ROWS_SMALL: r[ELEM_W*j +: ELEM_W] = q88_t'(int'($urandom_range(0, 1023)) - 512);
                ROWS_MAX:   r[ELEM_W*j +: ELEM_W] = Q_MAXV;
                ROWS_MIN:   r[ELEM_W*j +: ELEM_W] = Q_MINV;
                ROWS_IDENT: r[ELEM_W*j +: ELEM_W] = (j == row) ? Q_ONE : q88_t'(0);
                default:    r[ELEM_W*j +: ELEM_W] = '0;
            endcase
        end
        return r;
    endfunction

    // one register write, then cfg_we drops again before the task returns
    task automatic write_register(input logic [INDEX_W-1:0] index, input row_t value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index < DIM)
            row_shadow[index] = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_matrix(input row_kind_e kind);
        write_register(REG_ROW0, build_row(kind, 0));
        write_register(REG_ROW1, build_row(kind, 1));
        write_register(REG_ROW2, build_row(kind, 2));
        write_register(REG_ROW3, build_row(kind, 3));
        matrices_used++;
    endtask

    // offer one vector word and hold it until accepted
    task automatic send_vector(input vec_in_t v);
        bit taken;
        if (sender_idles)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken)
            begin
                pending_results.push_back(transform_vector(v));
                vectors_sent++;
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_random_vectors(input int count);
        for (int n = 0; n < count; n++)
            send_vector(random_vector());
    endtask

    // drop valid and let the pipeline empty before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns  ERROR  %s", $time, msg);
    endtask

    task automatic check_result(input vec_out_t got);
        vec_out_t want;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("result word with nothing pending: %h", got));
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (want.saturated)
            clipped_seen++;
        if (got.out_x !== want.out_x)
            report_error($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
        if (got.out_y !== want.out_y)
            report_error($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
        if (got.out_z !== want.out_z)
            report_error($sformatf("out_z got %0d want %0d", got.out_z, want.out_z));
        if (got.out_w !== want.out_w)
            report_error($sformatf("out_w got %0d want %0d", got.out_w, want.out_w));
        if (got.saturated !== want.saturated)
            report_error($sformatf("saturated got %b want %b", got.saturated,
                                   want.saturated));
    endtask

    // outputs are stable mid-cycle, the word moves at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            check_result(out_data);
    end

    // receiver: random stalls, plus a counted hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (receiver_idles && $urandom_range(0, 99) < IDLE_PCT)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("mat4_vec4_transform_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset matrix is the identity, so vectors pass through unchanged
    task automatic test_reset_identity();
        for (int i = 0; i < DIM; i++)
            row_shadow[i] = build_row(ROWS_IDENT, i);
        send_vector(make_vector(Q_MAXV, Q_MINV, '0, -16'sh0001));
        send_vector(make_vector(Q_LSB, Q_ONE, -16'sh0100, -16'sh7FFF));
        send_vector(make_vector(Q_MINV, Q_MAXV, -16'sh0001, '0));
        wait_drained();
    endtask

    // writes to indexes past the last row must leave the matrix alone
    task automatic test_ignored_index();
        write_register(REG_PAST_LAST, {4{Q_MAXV}});
        write_register(REG_TOP, {4{Q_MINV}});
        send_vector(make_vector(16'sh1234, -16'sh4321, Q_MAXV, Q_MINV));
        wait_drained();
    endtask

    // extreme matrices against extreme vectors, both directions of clipping
    task automatic test_saturation();
        load_matrix(ROWS_MAX);
        send_vector(make_vector(Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV));
        send_vector(make_vector(Q_MINV, Q_MINV, Q_MINV, Q_MINV));
        send_vector(make_vector('0, '0, '0, '0));
        send_vector(make_vector(Q_ONE, '0, '0, '0));
        wait_drained();
        load_matrix(ROWS_MIN);
        send_vector(make_vector(Q_MINV, Q_MINV, Q_MINV, Q_MINV));
        send_vector(make_vector(Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV));
        send_vector(make_vector(Q_MINV, '0, '0, '0));
        wait_drained();
    endtask

    // one lsb on the diagonal shows the floor rounding of negative sums
    task automatic test_floor_shift();
        write_register(REG_ROW0, diag_row(0, Q_LSB));
        write_register(REG_ROW1, diag_row(1, Q_LSB));
        write_register(REG_ROW2, diag_row(2, Q_LSB));
        write_register(REG_ROW3, diag_row(3, Q_LSB));
        matrices_used++;
        send_vector(make_vector(-16'sh0001, -16'sh0101, 16'sh00FF, Q_ONE));
        send_vector(make_vector(Q_LSB, -16'sh00FF, -16'sh0100, -16'sh0101));
        wait_drained();
    endtask

    // a run of matrix settings, each with a batch of random vectors
    task automatic test_random_matrices();
        row_kind_e kind;
        for (int p = 0; p < 14; p++)
        begin
            case (p)
                0:       kind = ROWS_MAX;
                1:       kind = ROWS_MIN;
                2:       kind = ROWS_ZERO;
                3:       kind = ROWS_IDENT;
                default: kind = (p % 3 == 0) ? ROWS_SMALL : ROWS_FULL;
            endcase
            load_matrix(kind);
            if ($urandom_range(0, 3) == 0)
                write_register(REG_PAST_LAST + INDEX_W'($urandom_range(0, 200)),
                               {$urandom, $urandom});
            send_random_vectors(100);
            wait_drained();
        end
    endtask

    // both sides flat out for a long stretch
    task automatic test_full_rate();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        load_matrix(ROWS_FULL);
        send_random_vectors(150);
        wait_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, pipeline backs up
    task automatic test_backpressure();
        sender_idles = 1'b0;
        load_matrix(ROWS_SMALL);
        hold_left = 150;
        send_random_vectors(50);
        wait_drained();
        sender_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_ignored_index();
        test_saturation();
        test_floor_shift();
        test_random_matrices();
        test_full_rate();
        test_backpressure();

        if (pending_results.size() != 0)
            report_error($sformatf("%0d result words never arrived",
                                   pending_results.size()));

        $display("covered %0d vectors over %0d matrix settings, %0d result words checked",
                 vectors_sent, matrices_used, results_seen);
        $display("%0d results clipped, ignored register indexes and a full backpressure hold",
                 clipped_seen);
        if (error_count == 0)
            $display("mat4_vec4_transform_test: done, clean");
        else
            $display("mat4_vec4_transform_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_mult.sv
hw/rtl/mvt_sum.sv
hw/rtl/mvt_sat.sv
hw/rtl/mat4_vec4_transform.sv
sim/mat4_vec4_transform_test.sv
